// ===== hw/rtl/wscfr_pkg.sv =====
// Shared types and constants of the WebSocket control-frame responder.
`default_nettype none
package wscfr_pkg;

   localparam int unsigned LEN_W  = 25;
   localparam int unsigned BEAT_W = 4;

   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;
   localparam logic [3:0] HDR_FIN  = 4'h8;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 25'd16777216;

   localparam logic [BEAT_W-1:0] LAST_SINGLE = 4'd0;
   localparam logic [BEAT_W-1:0] LAST_SHORT  = 4'd1;
   localparam logic [BEAT_W-1:0] LAST_MID    = 4'd3;
   localparam logic [BEAT_W-1:0] LAST_LONG   = 4'd9;

   typedef enum logic [1:0] {
      LINK_OPEN    = 2'd0,
      LINK_CLOSED  = 2'd1,
      LINK_DROPPED = 2'd2
   } link_type;

   typedef enum logic [1:0] {
      K_NONE = 2'd0,
      K_BYTE = 2'd1,
      K_HDR  = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      PH_HDR0 = 6'b000001,
      PH_HDR1 = 6'b000010,
      PH_EXT  = 6'b000100,
      PH_MASK = 6'b001000,
      PH_PAY  = 6'b010000,
      PH_DEAD = 6'b100000
   } phase_type;

   // One command per received byte: what the back end must send for it.
   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [LEN_W-1:0] len;
      link_type         link_end;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/websocket_control_frame_responder_top.sv =====
// Top level of the WebSocket control-frame responder.
`default_nettype none
// Takes one received byte per beat on the request side (push/full) and gives
// result beats on the response side (empty/pop). Every byte yields at least one
// beat; the byte that completes a ping or close header yields the echo header,
// two, four or ten beats, and an echoed payload byte yields one. The parser
// takes a byte every cycle while the command queue (QUEUE_DEPTH entries) has
// room; the sequencer sends one beat per cycle while pop is high, so a header
// burst holds the request side back only once the queue fills. A byte's first
// beat passes the queue, working and output registers. csr_max_payload is
// taken whenever csr_valid is high and applies to headers completed afterwards.
module websocket_control_frame_responder_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [7:0]                     req_rx_byte,
   output logic                                empty,
   input  wire logic                           pop,
   output logic                                rsp_tx_valid,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_tx_last,
   output logic [1:0]                          rsp_link_end,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [wscfr_pkg::LEN_W-1:0]    csr_max_payload
);
   import wscfr_pkg::*;

   cmd_type  front_cmd;
   cmd_type  q_head;
   logic     q_nonempty;
   logic     q_pop;
   logic     in_fire;

   assign csr_ready = 1'b1;
   assign in_fire   = push && !full;

   wscfr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_max_payload (csr_max_payload),
      .in_fire         (in_fire),
      .rx_byte         (req_rx_byte),
      .cmd             (front_cmd)
   );

   wscfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (in_fire),
      .din        (front_cmd),
      .pop_i      (q_pop),
      .dout       (q_head),
      .full_o     (full),
      .nonempty_o (q_nonempty)
   );

   wscfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .q_valid      (q_nonempty),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_tx_last  (rsp_tx_last),
      .rsp_link_end (rsp_link_end)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/wscfr_front.sv =====
// Frame header parser and payload unmasker: turns each received byte into a command.
`default_nettype none
module wscfr_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic [wscfr_pkg::LEN_W-1:0]    csr_max_payload,
   input  wire logic                           in_fire,
   input  wire logic [7:0]                     rx_byte,
   output wscfr_pkg::cmd_type                  cmd
);
   import wscfr_pkg::*;

   phase_type          phase_ff, phase_in;
   link_type           link_ff, link_in;
   logic [LEN_W-1:0]   max_ff, max_in;
   logic [3:0]         op_ff, op_in;
   logic               masked_ff, masked_in;
   logic [3:0]         ext_ff, ext_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               big_ff, big_in;
   logic [31:0]        key_ff, key_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [1:0]         midx_ff, midx_in;

   logic               hd_req;
   logic [LEN_W-1:0]   hd_len;
   logic               hd_big;
   logic               echo;
   logic [7:0]         key_byte;
   logic [7:0]         pay_byte;

   assign echo = (op_ff == OP_PING) || (op_ff == OP_CLOSE);

   always_comb begin
      unique case (midx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      pay_byte = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
   end

   always_comb begin
      phase_in  = phase_ff;
      link_in   = link_ff;
      max_in    = csr_valid ? csr_max_payload : max_ff;
      op_in     = op_ff;
      masked_in = masked_ff;
      ext_in    = ext_ff;
      len_in    = len_ff;
      big_in    = big_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      midx_in   = midx_ff;
      hd_req    = 1'b0;
      hd_len    = len_ff;
      hd_big    = big_ff;
      cmd       = '0;
      cmd.kind  = K_NONE;

      if (in_fire) begin
         unique case (phase_ff)
            PH_HDR0: begin
               op_in    = rx_byte[3:0];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = rx_byte[7];
               big_in    = 1'b0;
               if (rx_byte[6:0] == LEN_EXT16) begin
                  len_in   = '0;
                  ext_in   = 4'd2;
                  phase_in = PH_EXT;
               end else if (rx_byte[6:0] == LEN_EXT64) begin
                  len_in   = '0;
                  ext_in   = 4'd8;
                  phase_in = PH_EXT;
               end else begin
                  len_in = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
                  if (rx_byte[7]) begin
                     ext_in   = 4'd4;
                     phase_in = PH_MASK;
                  end else begin
                     hd_req = 1'b1;
                     hd_len = len_in;
                     hd_big = 1'b0;
                  end
               end
            end
            PH_EXT: begin
               // Keep the low bits exactly and fold anything above them into a sticky flag.
               len_in = {len_ff[LEN_W-9:0], rx_byte};
               big_in = big_ff | (len_ff[LEN_W-1:LEN_W-8] != 8'd0);
               ext_in = ext_ff - 4'd1;
               if (ext_ff == 4'd1) begin
                  if (masked_ff) begin
                     ext_in   = 4'd4;
                     phase_in = PH_MASK;
                  end else begin
                     hd_req = 1'b1;
                     hd_len = len_in;
                     hd_big = big_in;
                  end
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               ext_in = ext_ff - 4'd1;
               if (ext_ff == 4'd1) begin
                  hd_req = 1'b1;
               end
            end
            PH_PAY: begin
               midx_in = midx_ff + 2'd1;
               if (echo) begin
                  cmd.kind = K_BYTE;
                  cmd.data = pay_byte;
               end
               left_in = left_ff - 1'b1;
               if (left_ff == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                  if (op_ff == OP_CLOSE) begin
                     link_in  = LINK_CLOSED;
                     phase_in = PH_DEAD;
                  end else begin
                     phase_in = PH_HDR0;
                  end
               end
            end
            PH_DEAD: begin
            end
            default: begin
               phase_in = PH_DEAD;
            end
         endcase

         if (hd_req) begin
            if (hd_big || (hd_len > max_ff)) begin
               link_in  = LINK_DROPPED;
               phase_in = PH_DEAD;
            end else begin
               left_in = hd_len;
               midx_in = 2'd0;
               if (echo) begin
                  cmd.kind = K_HDR;
                  cmd.data = {HDR_FIN, (op_ff == OP_PING) ? OP_PONG : OP_CLOSE};
                  cmd.len  = hd_len;
               end
               if (hd_len == '0) begin
                  if (op_ff == OP_CLOSE) begin
                     link_in  = LINK_CLOSED;
                     phase_in = PH_DEAD;
                  end else begin
                     phase_in = PH_HDR0;
                  end
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
      end
      cmd.link_end = link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         link_ff   <= LINK_OPEN;
         max_ff    <= MAX_PAYLOAD_RESET;
         op_ff     <= 4'd0;
         masked_ff <= 1'b0;
         ext_ff    <= 4'd0;
         left_ff   <= '0;
         midx_ff   <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         link_ff   <= link_in;
         max_ff    <= max_in;
         op_ff     <= op_in;
         masked_ff <= masked_in;
         ext_ff    <= ext_in;
         left_ff   <= left_in;
         midx_ff   <= midx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      big_ff <= big_in;
      key_ff <= key_in;
   end

   a_link_sticky: assert property (@(posedge clock) disable iff (reset)
      (link_ff != LINK_OPEN) |=> (link_ff == $past(link_ff)))
      else $error("link end state changed after the link ended");

   a_dead_when_ended: assert property (@(posedge clock) disable iff (reset)
      (link_ff != LINK_OPEN) |-> (phase_ff == PH_DEAD))
      else $error("parser still active on an ended link");

endmodule
`default_nettype wire

// ===== hw/rtl/wscfr_queue.sv =====
// Short command queue between the parser and the transmit sequencer.
`default_nettype none
module wscfr_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_i,
   input  wire wscfr_pkg::cmd_type  din,
   input  wire logic                pop_i,
   output wscfr_pkg::cmd_type       dout,
   output logic                     full_o,
   output logic                     nonempty_o
);
   import wscfr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full_o     = (count_ff == CNT_FULL);
   assign nonempty_o = (count_ff != '0);
   assign dout       = mem_ff[rd_ff];
   assign do_push    = push_i && !full_o;
   assign do_pop     = pop_i && nonempty_o;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("command queue count beyond its depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full_o |-> !push_i)
      else $error("command pushed into a full queue");

endmodule
`default_nettype wire

// ===== hw/rtl/wscfr_back.sv =====
// Transmit sequencer: expands commands into result beats behind an output register.
`default_nettype none
module wscfr_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire wscfr_pkg::cmd_type         q_head,
   input  wire logic                       q_valid,
   output logic                            q_pop,
   input  wire logic                       pop,
   output logic                            empty,
   output logic                            rsp_tx_valid,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_tx_last,
   output logic [1:0]                      rsp_link_end
);
   import wscfr_pkg::*;

   logic                w_valid_ff, w_valid_in;
   cmd_type             w_cmd_ff, w_cmd_in;
   logic [BEAT_W-1:0]   w_idx_ff, w_idx_in;

   logic                o_valid_ff, o_valid_in;
   logic                o_txv_ff, o_txv_in;
   logic [7:0]          o_byte_ff, o_byte_in;
   logic                o_last_ff, o_last_in;
   link_type            o_link_ff, o_link_in;

   logic [BEAT_W-1:0]   last_idx;
   logic [7:0]          beat_byte;
   logic                load_out;
   logic                beat_last;
   logic                w_free;
   logic                len_short;
   logic                len_mid;

   assign len_short = (w_cmd_ff.len < LEN_W'(126));
   assign len_mid   = (w_cmd_ff.len[LEN_W-1:16] == '0);

   always_comb begin
      last_idx  = LAST_SINGLE;
      beat_byte = 8'd0;
      unique case (w_cmd_ff.kind)
         K_BYTE: begin
            beat_byte = w_cmd_ff.data;
         end
         K_HDR: begin
            priority if (len_short) begin
               last_idx = LAST_SHORT;
            end else if (len_mid) begin
               last_idx = LAST_MID;
            end else begin
               last_idx = LAST_LONG;
            end
            // Length goes out big-endian in the shortest form that holds it.
            priority if (w_idx_ff == 4'd0) begin
               beat_byte = w_cmd_ff.data;
            end else if (len_short) begin
               beat_byte = w_cmd_ff.len[7:0];
            end else if (len_mid) begin
               unique case (w_idx_ff)
                  4'd1:    beat_byte = {1'b0, LEN_EXT16};
                  4'd2:    beat_byte = w_cmd_ff.len[15:8];
                  default: beat_byte = w_cmd_ff.len[7:0];
               endcase
            end else begin
               unique case (w_idx_ff)
                  4'd1:    beat_byte = {1'b0, LEN_EXT64};
                  4'd6:    beat_byte = {7'd0, w_cmd_ff.len[24]};
                  4'd7:    beat_byte = w_cmd_ff.len[23:16];
                  4'd8:    beat_byte = w_cmd_ff.len[15:8];
                  4'd9:    beat_byte = w_cmd_ff.len[7:0];
                  default: beat_byte = 8'd0;
               endcase
            end
         end
         default: begin
            beat_byte = 8'd0;
         end
      endcase
   end

   assign load_out  = w_valid_ff && (!o_valid_ff || pop);
   assign beat_last = (w_idx_ff == last_idx);
   assign w_free    = !w_valid_ff || (load_out && beat_last);
   assign q_pop     = q_valid && w_free;

   always_comb begin
      w_valid_in = w_valid_ff;
      w_cmd_in   = w_cmd_ff;
      w_idx_in   = w_idx_ff;
      if (q_pop) begin
         w_valid_in = 1'b1;
         w_cmd_in   = q_head;
         w_idx_in   = '0;
      end else if (load_out && beat_last) begin
         w_valid_in = 1'b0;
      end else if (load_out) begin
         w_idx_in = w_idx_ff + 1'b1;
      end

      o_valid_in = o_valid_ff;
      o_txv_in   = o_txv_ff;
      o_byte_in  = o_byte_ff;
      o_last_in  = o_last_ff;
      o_link_in  = o_link_ff;
      if (load_out) begin
         o_valid_in = 1'b1;
         o_txv_in   = (w_cmd_ff.kind != K_NONE);
         o_byte_in  = beat_byte;
         o_last_in  = beat_last;
         o_link_in  = w_cmd_ff.link_end;
      end else if (pop) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         w_idx_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= w_valid_in;
         w_idx_ff   <= w_idx_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_cmd_ff  <= w_cmd_in;
      o_txv_ff  <= o_txv_in;
      o_byte_ff <= o_byte_in;
      o_last_ff <= o_last_in;
      o_link_ff <= o_link_in;
   end

   assign empty        = !o_valid_ff;
   assign rsp_tx_valid = o_txv_ff;
   assign rsp_tx_byte  = o_byte_ff;
   assign rsp_tx_last  = o_last_ff;
   assign rsp_link_end = o_link_ff;

   a_idle_beat_last: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_txv_ff) |-> (o_last_ff && (o_byte_ff == 8'd0)))
      else $error("idle beat not marked as the final beat");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      w_valid_ff |-> (w_idx_ff <= last_idx))
      else $error("beat index ran past the command's last beat");

endmodule
`default_nettype wire
